FILE: rtl/svl_pkg.sv
// Shared types and constants for the sorted value list.
`timescale 1ns / 1ps

package svl_pkg;

    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 7;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 104;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [MODE_W-1:0] {
        OP_INSERT    = 2'd0,
        OP_DELETE    = 2'd1,
        OP_READ_ASC  = 2'd2,
        OP_READ_DESC = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        op_t                       op;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

endpackage

FILE: rtl/svl_front.sv
// Input stage: accepts request words, decodes the mode and hands commands to the queue.
`timescale 1ns / 1ps

module svl_front
    import svl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [MODE_W-1:0]    s_tuser,
    input  logic [IN_DATA_W-1:0] s_tdata,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output cmd_t                 cmd
);

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t hold_reg;
    cmd_t decoded;

    always_comb
    begin
        decoded.op    = op_t'(s_tuser);
        decoded.value = $signed(s_tdata[VALUE_W-1:0]);
    end

    assign s_tready  = !hold_valid_reg || cmd_ready;
    assign cmd_valid = hold_valid_reg;
    assign cmd       = hold_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (s_tvalid && s_tready)
        begin
            hold_valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            hold_reg <= decoded;
        end
    end

endmodule

FILE: rtl/svl_queue.sv
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module svl_queue
    import svl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop,
    output cmd_t pop_cmd
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/svl_back.sv
// Execution stage: sorted shift array, command sequencer and output register.
`timescale 1ns / 1ps

module svl_back
    import svl_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_pop,
    input  cmd_t                  cmd,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [STATUS_W-1:0]   m_tuser,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } state_t;

    state_t                    state_reg;
    op_t                       op_reg;
    status_t                   status_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic                      out_valid_reg;
    logic                      out_last_reg;
    status_t                   out_status_reg;
    logic [OUT_DATA_W-1:0]     out_data_reg;

    logic signed [VALUE_W-1:0] store_reg [CAPACITY];
    logic signed [VALUE_W-1:0] store_next [CAPACITY];
    logic                      store_we;

    logic [CAPACITY-1:0]       le;
    logic [CAPACITY-1:0]       lt;
    logic [CAPACITY-1:0]       eq;
    logic [CAPACITY-1:0]       le_prev;
    logic signed [VALUE_W-1:0] shift_up [CAPACITY];
    logic signed [VALUE_W-1:0] shift_dn [CAPACITY];
    logic signed [VALUE_W-1:0] ins_next [CAPACITY];
    logic signed [VALUE_W-1:0] del_next [CAPACITY];
    logic                      full;
    logic                      found;

    logic [CNT_W-1:0]          count_m1;
    logic [IDX_W-1:0]          sel;
    logic                      is_read;
    logic                      at_last;
    logic                      out_free;
    logic                      out_load;
    logic                      is_empty;
    logic signed [VALUE_W-1:0] item;
    logic signed [VALUE_W-1:0] min_v;
    logic signed [VALUE_W-1:0] max_v;

    // Compare every cell against the request value in parallel
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            le[i] = (CNT_W'(i) < count_reg) && (store_reg[i] <= cmd.value);
            lt[i] = (CNT_W'(i) < count_reg) && (store_reg[i] < cmd.value);
            eq[i] = (CNT_W'(i) < count_reg) && (store_reg[i] == cmd.value);
        end
        le_prev     = {le[CAPACITY-2:0], 1'b1};
        shift_up[0] = cmd.value;
        for (int i = 1; i < CAPACITY; i++)
        begin
            shift_up[i] = store_reg[i-1];
        end
        for (int i = 0; i < CAPACITY - 1; i++)
        begin
            shift_dn[i] = store_reg[i+1];
        end
        shift_dn[CAPACITY-1] = store_reg[CAPACITY-1];
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (le[i])
            begin
                ins_next[i] = store_reg[i];
            end
            else if (le_prev[i])
            begin
                ins_next[i] = cmd.value;
            end
            else
            begin
                ins_next[i] = shift_up[i];
            end
            del_next[i] = lt[i] ? store_reg[i] : shift_dn[i];
        end
    end

    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign found    = |eq;
    assign count_m1 = count_reg - CNT_W'(1);
    assign is_empty = (count_reg == '0);
    assign is_read  = ((op_reg == OP_READ_ASC) || (op_reg == OP_READ_DESC))
                      && (status_reg == ST_OK);
    assign sel      = (op_reg == OP_READ_ASC) ? idx_reg : count_m1[IDX_W-1:0] - idx_reg;
    assign at_last  = (idx_reg == count_m1[IDX_W-1:0]);
    assign item     = is_read ? store_reg[sel] : '0;
    assign min_v    = is_empty ? '0 : store_reg[0];
    assign max_v    = is_empty ? '0 : store_reg[count_m1[IDX_W-1:0]];
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = (state_reg == S_EMIT) && out_free;
    assign cmd_pop  = (state_reg == S_IDLE) && cmd_valid;

    always_comb
    begin
        store_we   = 1'b0;
        store_next = ins_next;
        if (cmd_pop)
        begin
            case (cmd.op)
                OP_INSERT:
                begin
                    store_we = !full;
                end
                OP_DELETE:
                begin
                    store_we   = found;
                    store_next = del_next;
                end
                default:
                begin
                    store_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_INSERT;
            status_reg     <= ST_OK;
            count_reg      <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
            out_status_reg <= ST_OK;
            out_data_reg   <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        op_reg    <= cmd.op;
                        idx_reg   <= '0;
                        state_reg <= S_EMIT;
                        case (cmd.op)
                            OP_INSERT:
                            begin
                                if (full)
                                begin
                                    status_reg <= ST_FULL;
                                end
                                else
                                begin
                                    status_reg <= ST_OK;
                                    count_reg  <= count_reg + CNT_W'(1);
                                end
                            end
                            OP_DELETE:
                            begin
                                if (found)
                                begin
                                    status_reg <= ST_OK;
                                    count_reg  <= count_m1;
                                end
                                else
                                begin
                                    status_reg <= ST_NOT_FOUND;
                                end
                            end
                            default:
                            begin
                                status_reg <= is_empty ? ST_EMPTY : ST_OK;
                            end
                        endcase
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_status_reg <= status_reg;
                        out_last_reg   <= !is_read || at_last;
                        out_data_reg   <= {is_empty, max_v, min_v,
                                           COUNT_W'(count_reg), item};
                        if (!is_read || at_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + IDX_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg <= store_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: rtl/sorted_value_list.sv
// Top level of the sorted value list: front end, command queue and back end.
`timescale 1ns / 1ps

// Keeps up to CAPACITY signed 32-bit values in ascending order in a shift array of
// registers. Requests enter on the slave stream (tuser = mode, tdata = value), are held
// in a two-entry command queue and run one at a time. An insert or delete compares all
// cells and shifts the array when the request is picked up, then loads the output
// register in the emit state. A read-out sets up when picked up and then sends one word
// per cycle while the master side keeps taking them; an empty read-out sends one word flagged empty. The output
// register lets the next request be picked up while a result waits on the master side.

module sorted_value_list
    import svl_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [MODE_W-1:0]     s_axis_tuser,   // mode
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // value
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [STATUS_W-1:0]   m_axis_tuser,   // status
    // item_value, count, min_value, max_value, is_empty
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    logic front_valid;
    logic front_ready;
    cmd_t front_cmd;
    logic queue_valid;
    logic queue_pop;
    cmd_t queue_cmd;

    svl_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_tuser   (s_axis_tuser),
        .s_tdata   (s_axis_tdata),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    svl_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (queue_valid),
        .pop        (queue_pop),
        .pop_cmd    (queue_cmd)
    );

    svl_back #(
        .CAPACITY (CAPACITY)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd_pop   (queue_pop),
        .cmd       (queue_cmd),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tuser   (m_axis_tuser),
        .m_tdata   (m_axis_tdata),
        .m_tlast   (m_axis_tlast)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[38:32] <= COUNT_W'(CAPACITY)))
        else $error("count above capacity");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[103] == (m_axis_tdata[38:32] == '0)))
        else $error("empty flag disagrees with count");

    a_empty_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[103]) |->
            (m_axis_tdata[70:39] == '0 && m_axis_tdata[102:71] == '0))
        else $error("bounds not zero on empty store");

    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[103]) |->
            ($signed(m_axis_tdata[70:39]) <= $signed(m_axis_tdata[102:71])))
        else $error("minimum above maximum");

    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_EMPTY || m_axis_tuser == ST_FULL
                           || m_axis_tuser == ST_NOT_FOUND)) |-> m_axis_tlast)
        else $error("flagged result not last");

endmodule

FILE: tb/tb_sorted_value_list.sv
// Self-checking testbench for the sorted value list, with a scoreboard that mirrors the store.
`timescale 1ns / 1ps

module tb_sorted_value_list;
    import svl_pkg::*;

    localparam int CAPACITY = 16;

    typedef struct {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] item_value;
        logic                      is_last;
        logic [COUNT_W-1:0]        count;
        logic signed [VALUE_W-1:0] min_value;
        logic signed [VALUE_W-1:0] max_value;
        logic                      is_empty;
    } list_word_t;

    class sorted_list_scoreboard;
        logic signed [VALUE_W-1:0] contents[$];
        list_word_t                pending[$];
        int unsigned               mismatches;

        function void queue_word(logic [STATUS_W-1:0] status, logic signed [VALUE_W-1:0] item,
                                 logic is_last);
            list_word_t w;
            w.status     = status;
            w.item_value = item;
            w.is_last    = is_last;
            w.count      = COUNT_W'(contents.size());
            w.is_empty   = (contents.size() == 0);
            w.min_value  = w.is_empty ? '0 : contents[0];
            w.max_value  = w.is_empty ? '0 : contents[contents.size() - 1];
            pending.push_back(w);
        endfunction

        function void note_request(op_t op, logic signed [VALUE_W-1:0] operand);
            int pos;
            int n;
            pos = 0;
            n   = contents.size();
            case (op)
                OP_INSERT:
                begin
                    if (n >= CAPACITY)
                    begin
                        queue_word(ST_FULL, '0, 1'b1);
                    end
                    else
                    begin
                        while (pos < n && contents[pos] <= operand)
                            pos++;
                        contents.insert(pos, operand);
                        queue_word(ST_OK, '0, 1'b1);
                    end
                end
                OP_DELETE:
                begin
                    while (pos < n && contents[pos] < operand)
                        pos++;
                    if (pos >= n || contents[pos] != operand)
                    begin
                        queue_word(ST_NOT_FOUND, '0, 1'b1);
                    end
                    else
                    begin
                        contents.delete(pos);
                        queue_word(ST_OK, '0, 1'b1);
                    end
                end
                default:
                begin
                    if (n == 0)
                        queue_word(ST_EMPTY, '0, 1'b1);
                    for (int i = 0; i < n; i++)
                        queue_word(ST_OK, (op == OP_READ_ASC) ? contents[i] : contents[n - 1 - i],
                                   i == n - 1);
                end
            endcase
        endfunction

        task flag_mismatch(string field, logic [31:0] got, logic [31:0] wanted);
            $display("%0t ns: mismatch on %s: got %h, wanted %h", $time, field, got, wanted);
            mismatches++;
        endtask

        task check_result(logic [STATUS_W-1:0] status, logic [OUT_DATA_W-1:0] data,
                          logic is_last);
            list_word_t w;
            if (pending.size() == 0)
            begin
                flag_mismatch("unexpected word", data[31:0], '0);
                return;
            end
            w = pending.pop_front();
            if (status !== w.status)
                flag_mismatch("status", 32'(status), 32'(w.status));
            if (data[31:0] !== w.item_value)
                flag_mismatch("item_value", data[31:0], w.item_value);
            if (is_last !== w.is_last)
                flag_mismatch("last", 32'(is_last), 32'(w.is_last));
            if (data[38:32] !== w.count)
                flag_mismatch("count", 32'(data[38:32]), 32'(w.count));
            if (data[70:39] !== w.min_value)
                flag_mismatch("min_value", data[70:39], w.min_value);
            if (data[102:71] !== w.max_value)
                flag_mismatch("max_value", data[102:71], w.max_value);
            if (data[103] !== w.is_empty)
                flag_mismatch("is_empty", 32'(data[103]), 32'(w.is_empty));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [MODE_W-1:0]     s_axis_tuser = '0;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [STATUS_W-1:0]   m_axis_tuser;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    sorted_list_scoreboard sb = new;
    int unsigned           tx_idle_pct = 12;
    int unsigned           rx_idle_pct = 88;
    int unsigned           requests_sent = 0;

    sorted_value_list #(.CAPACITY(CAPACITY)) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #4_000_000;
        $display("tb_sorted_value_list NOT OK");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end

    // Receiver: random stalls, plus one long hold-off to back the block up.
    initial
    begin
        int unsigned hold_left;
        bit          held;
        hold_left = 0;
        held      = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && requests_sent >= 350)
            begin
                held      = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return $urandom;
            default: return $urandom_range(0, 15) - 8;
        endcase
    endfunction

    task automatic send_request(op_t op, logic [31:0] operand);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= operand;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(op, operand);
        requests_sent++;
    endtask

    initial
    begin
        logic [31:0] fill_values [16];
        op_t         op;
        logic [31:0] operand;
        int          fill;
        int unsigned roll;
        bit          filling;
        fill_values = '{
            32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
            32'h0000_0001, 32'h0000_0007, 32'h0000_0007, 32'hFFFF_FFF9,
            32'h8000_0001, 32'h7FFF_FFFE, 32'h0000_0064, 32'hFFFF_FF9C,
            32'h0000_0007, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0003
        };
        filling = 1'b1;

        wait (rst_n === 1'b1);
        @(posedge clk);

        // empty store: read-outs and a delete that cannot hit
        send_request(OP_READ_ASC, 32'h0);
        send_request(OP_READ_DESC, 32'hFFFF_FFFF);
        send_request(OP_DELETE, 32'd5);
        // fill with extremes and duplicates, then overflow
        foreach (fill_values[i])
            send_request(OP_INSERT, fill_values[i]);
        send_request(OP_INSERT, 32'd42);
        send_request(OP_READ_ASC, 32'h0);
        send_request(OP_READ_DESC, 32'h0);
        send_request(OP_DELETE, 32'd7);
        send_request(OP_DELETE, 32'd12345);
        send_request(OP_DELETE, 32'h8000_0000);

        // alternate between filling and draining so the count sweeps its range
        for (int n = 0; n < 450; n++)
        begin
            if (n == 150)
            begin
                tx_idle_pct = 88;
                rx_idle_pct = 12;
            end
            if (n == 300)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            fill = sb.contents.size();
            if (filling && fill >= CAPACITY && $urandom_range(0, 2) == 0)
                filling = 1'b0;
            else if (!filling && fill == 0 && $urandom_range(0, 1) == 0)
                filling = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 8)
                op = OP_READ_ASC;
            else if (roll < 15)
                op = OP_READ_DESC;
            else if (roll < 30)
                op = filling ? OP_DELETE : OP_INSERT;
            else
                op = filling ? OP_INSERT : OP_DELETE;
            if (op == OP_DELETE && fill > 0 && $urandom_range(0, 4) != 0)
                operand = sb.contents[$urandom_range(0, fill - 1)];
            else
                operand = pick_value();
            send_request(op, operand);
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0)
            $display("tb_sorted_value_list OK");
        else
            $display("tb_sorted_value_list NOT OK");
        $finish;
    end

endmodule

FILE: files.f
rtl/svl_pkg.sv
rtl/svl_front.sv
rtl/svl_queue.sv
rtl/svl_back.sv
rtl/sorted_value_list.sv
tb/tb_sorted_value_list.sv
